>>> rtl/core/spm_pkg.sv
// shared constants, codes and controller/datapath types for the sparse paged memory
package spm_pkg;

    localparam int MAX_PAGES_DEF  = 16;
    localparam int PAGE_WORDS_DEF = 1024;

    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 32;
    localparam int WORD_IDX_W = 30;
    localparam int LIMIT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;

    localparam logic [1:0] ALIGN_MASK = 2'd3;

    localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST = 5'd16;
    localparam logic [PADDR_W-1:0] REG_PAGE_LIMIT = 2'd0;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LIMIT    = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_LOOKUP,
        ST_ADDR,
        ST_DISPATCH,
        ST_READ,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        RES_DONE,
        RES_BAD_ADDR,
        RES_LIMIT,
        RES_READ
    } res_sel_t;

    typedef struct packed {
        logic     accept;
        logic     clear_step;
        logic     div_step;
        logic     lookup;
        logic     addr_calc;
        logic     mem_read;
        logic     mem_write;
        logic     alloc;
        logic     load_out;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic bad_addr;
        logic div_done;
        logic is_write;
        logic hit;
        logic room;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/spm_ram.sv
// generic single-port ram with registered read
module spm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/spm_ctrl.sv
// controller state machine sequencing one word request at a time
module spm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output spm_pkg::dp_cmd_t  cmd,
    input  spm_pkg::dp_stat_t stat
);

    import spm_pkg::*;

    state_t   state_reg;
    state_t   state_next;
    res_sel_t res_sel_reg;
    res_sel_t res_sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            res_sel_reg <= RES_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (stat.bad_addr)
                begin
                    res_sel_next = RES_BAD_ADDR;
                    state_next   = ST_RESP;
                end
                else if (stat.div_done)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (!stat.is_write)
                begin
                    if (stat.hit)
                    begin
                        res_sel_next = RES_READ;
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        res_sel_next = RES_DONE;
                        state_next   = ST_RESP;
                    end
                end
                else if (stat.hit || stat.room)
                begin
                    res_sel_next = RES_DONE;
                    state_next   = ST_RESP;
                end
                else
                begin
                    res_sel_next = RES_LIMIT;
                    state_next   = ST_RESP;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_SPLIT:
            begin
                cmd.div_step = 1'b1;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            ST_ADDR:
            begin
                cmd.addr_calc = 1'b1;
            end
            ST_DISPATCH:
            begin
                // a write to a new page claims slot pages_used
                cmd.mem_write = stat.is_write && (stat.hit || stat.room);
                cmd.alloc     = stat.is_write && !stat.hit && stat.room;
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
            end
            ST_RESP:
            begin
                cmd.load_out = stat.out_free;
                cmd.res_sel  = res_sel_reg;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/spm_dp.sv
// datapath: address split, tag table, page store and result register
module spm_dp #(
    parameter int MAX_PAGES  = spm_pkg::MAX_PAGES_DEF,
    parameter int PAGE_WORDS = spm_pkg::PAGE_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  spm_pkg::dp_cmd_t               cmd,
    output spm_pkg::dp_stat_t              stat,
    input  logic                           action,
    input  logic [spm_pkg::ADDR_W-1:0]     address,
    input  logic [spm_pkg::DATA_W-1:0]     write_data,
    input  logic [spm_pkg::LIMIT_W-1:0]    page_limit,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [spm_pkg::DATA_W-1:0]     read_data,
    output logic [spm_pkg::STATUS_W-1:0]   status
);

    import spm_pkg::*;

    localparam int PW_LOG  = $clog2(PAGE_WORDS);
    localparam bit PW_POW2 = ((1 << PW_LOG) == PAGE_WORDS);
    localparam int OFF_W   = (PW_LOG > 0) ? PW_LOG : 1;
    localparam int TAG_W   = 31 - $clog2(PAGE_WORDS + 1);
    localparam int SLOT_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W   = $clog2(MAX_PAGES + 1);
    localparam int DEPTH   = MAX_PAGES * PAGE_WORDS;
    localparam int MEM_AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    logic              action_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic              bad_reg;

    logic [TAG_W-1:0]  page_tag_w;
    logic [OFF_W-1:0]  page_off_w;
    logic              div_done;

    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [TAG_W-1:0]  tag_table_reg [MAX_PAGES];
    logic [CNT_W-1:0]  pages_used_reg;
    logic [MAX_PAGES-1:0] match_reg;

    logic              found;
    logic [SLOT_W-1:0] slot_found;
    logic [SLOT_W-1:0] slot_sel;
    logic [31:0]       slot_base;
    logic              room_w;

    logic [MEM_AW-1:0] mem_addr_reg;
    logic              hit_reg;
    logic              room_reg;

    logic              ram_en;
    logic              ram_we;
    logic [MEM_AW-1:0] ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   read_data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                out_free;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= action;
            wdata_reg  <= write_data;
            bad_reg    <= (address == '0) || ((address[1:0] & ALIGN_MASK) != 2'd0);
        end
    end

    // split word index into page tag and word offset
    generate
        if (PW_POW2)
        begin : g_shift
            logic [WORD_IDX_W-1:0] word_reg;

            always_ff @(posedge clk)
            begin
                if (cmd.accept)
                begin
                    word_reg <= address[ADDR_W-1:2];
                end
            end

            assign page_tag_w = TAG_W'(word_reg >> PW_LOG);
            assign page_off_w = OFF_W'(word_reg & WORD_IDX_W'(PAGE_WORDS - 1));
            assign div_done   = 1'b1;
        end
        else
        begin : g_div
            localparam int MUL_SH = WORD_IDX_W + PW_LOG;
            localparam int PROD_W = 2 * WORD_IDX_W + 1;
            // rounded-up reciprocal, exact quotient for every word index
            localparam logic [WORD_IDX_W:0] RECIP =
                (WORD_IDX_W + 1)'(((64'd1 << MUL_SH) + 64'(PAGE_WORDS - 1)) /
                                  64'(PAGE_WORDS));

            logic [1:0]            div_cnt_reg;
            logic [WORD_IDX_W-1:0] word_reg;
            logic [PROD_W-1:0]     prod_reg;
            logic [WORD_IDX_W-1:0] quo_w;
            logic [WORD_IDX_W-1:0] quo_reg;
            logic [OFF_W-1:0]      rem_reg;

            assign quo_w = WORD_IDX_W'(prod_reg >> MUL_SH);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    div_cnt_reg <= '0;
                end
                else if (cmd.accept)
                begin
                    div_cnt_reg <= '0;
                end
                else if (cmd.div_step && !div_done)
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
            end

            // first step multiplies by the reciprocal, second registers the quotient and forms the remainder
            always_ff @(posedge clk)
            begin
                if (cmd.accept)
                begin
                    word_reg <= address[ADDR_W-1:2];
                end
                else if (cmd.div_step && !div_done)
                begin
                    if (div_cnt_reg == 2'd0)
                    begin
                        prod_reg <= PROD_W'(word_reg) * PROD_W'(RECIP);
                    end
                    else
                    begin
                        quo_reg <= quo_w;
                        rem_reg <= OFF_W'(word_reg - quo_w * WORD_IDX_W'(PAGE_WORDS));
                    end
                end
            end

            assign div_done   = (div_cnt_reg == 2'd2);
            assign page_tag_w = TAG_W'(quo_reg);
            assign page_off_w = rem_reg;
        end
    endgenerate

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // tag table and page count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                tag_table_reg[i] <= '0;
            end
            pages_used_reg <= CNT_W'(1);
        end
        else if (cmd.alloc)
        begin
            tag_table_reg[pages_used_reg[SLOT_W-1:0]] <= page_tag_w;
            pages_used_reg <= pages_used_reg + 1'b1;
        end
    end

    // slots below pages_used are the live ones
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                match_reg[i] <= (CNT_W'(i) < pages_used_reg) &&
                                (tag_table_reg[i] == page_tag_w);
            end
        end
    end

    // tags are unique, so at most one match bit is set
    always_comb
    begin
        slot_found = '0;
        for (int i = 0; i < MAX_PAGES; i++)
        begin
            if (match_reg[i])
            begin
                slot_found = slot_found | SLOT_W'(i);
            end
        end
    end

    assign found     = |match_reg;
    assign slot_sel  = found ? slot_found : pages_used_reg[SLOT_W-1:0];
    assign slot_base = 32'(slot_sel) * 32'(PAGE_WORDS);
    assign room_w    = (LIM_W'(pages_used_reg) < LIM_W'(page_limit)) &&
                       (LIM_W'(pages_used_reg) < LIM_W'(MAX_PAGES));

    always_ff @(posedge clk)
    begin
        if (cmd.addr_calc)
        begin
            mem_addr_reg <= MEM_AW'(slot_base) + MEM_AW'(page_off_w);
            hit_reg      <= found;
            room_reg     <= room_w;
        end
    end

    // page store
    assign ram_en    = cmd.clear_step | cmd.mem_read | cmd.mem_write;
    assign ram_we    = cmd.clear_step | cmd.mem_write;
    assign ram_addr  = cmd.clear_step ? clr_cnt_reg : mem_addr_reg;
    assign ram_wdata = cmd.clear_step ? '0 : wdata_reg;

    spm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // result register
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_data_reg <= (cmd.res_sel == RES_READ) ? ram_rdata : '0;
            case (cmd.res_sel)
                RES_BAD_ADDR: status_reg <= STATUS_BAD_ADDR;
                RES_LIMIT:    status_reg <= STATUS_LIMIT;
                default:      status_reg <= STATUS_DONE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

    assign stat.clear_last = (clr_cnt_reg == MEM_AW'(DEPTH - 1));
    assign stat.bad_addr   = bad_reg;
    assign stat.div_done   = div_done;
    assign stat.is_write   = action_reg;
    assign stat.hit        = hit_reg;
    assign stat.room       = room_reg;
    assign stat.out_free   = out_free;

endmodule

>>> rtl/core/sparse_paged_word_memory.sv
// a word passes split, lookup, address, dispatch (and read, on a read hit) and then the
// response state; a bad address goes from split to response; a page size that is not a
// power of two adds a multiply and a remainder step to split; one word in flight, set by
// the sequencing controller and the single page store port; a stalled result holds the
// input off; reset: page zero live, limit 16; a clearing pass over all
// MAX_PAGES*PAGE_WORDS words (16384 at default size) zeroes the store with in_stall high
module sparse_paged_word_memory #(
    parameter int MAX_PAGES  = spm_pkg::MAX_PAGES_DEF,
    parameter int PAGE_WORDS = spm_pkg::PAGE_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spm_pkg::PADDR_W-1:0]    paddr,
    input  logic [spm_pkg::PDATA_W-1:0]    pwdata,
    output logic [spm_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [spm_pkg::ADDR_W-1:0]     address,
    input  logic [spm_pkg::DATA_W-1:0]     write_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [spm_pkg::DATA_W-1:0]     read_data,
    output logic [spm_pkg::STATUS_W-1:0]   status
);

    import spm_pkg::*;

    logic [LIMIT_W-1:0] page_limit_reg;
    logic               cfg_wr;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_PAGE_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_limit_reg <= PAGE_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            page_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr == REG_PAGE_LIMIT) ? PDATA_W'(page_limit_reg) : '0;

    spm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    spm_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_WORDS (PAGE_WORDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (action),
        .address    (address),
        .write_data (write_data),
        .page_limit (page_limit_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .status     (status)
    );

endmodule

>>> rtl/core/spm_checker.sv
// port-level checks for the sparse paged memory, bound to the top level
module spm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [spm_pkg::DATA_W-1:0]     read_data,
    input logic [spm_pkg::STATUS_W-1:0]   status
);

    import spm_pkg::*;

    // one word in flight: the cycle after an accept never accepts again
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word accepted while one is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(status)))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_DONE || status == STATUS_BAD_ADDR ||
                       status == STATUS_LIMIT))
        else $error("unknown status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_DONE) |-> (read_data == '0))
        else $error("error result carries nonzero data");

endmodule

bind sparse_paged_word_memory spm_checker u_spm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .status    (status)
);

>>> bench/testbench.sv
// self-checking bench for the sparse paged word memory: directed and random requests over page limits
module testbench;
    import spm_pkg::*;

    localparam int MAX_PAGES   = MAX_PAGES_DEF;
    localparam int PAGE_WORDS  = PAGE_WORDS_DEF;
    localparam int TAG_SPAN    = (1 << WORD_IDX_W) / PAGE_WORDS;
    localparam int TAGS        = 24;
    localparam int BATCH_WORDS = 250;
    localparam int QUIET_LIMIT = 60000;
    localparam int HOLD_CYCLES = 400;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic              act;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } request_t;

    typedef struct packed {
        logic [DATA_W-1:0]   rdata;
        logic [STATUS_W-1:0] code;
    } reply_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [PADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic                action     = ACT_READ;
    logic [ADDR_W-1:0]   address    = '0;
    logic [DATA_W-1:0]   write_data = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [DATA_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;

    // shadow of the memory contents and page table
    logic [WORD_IDX_W-1:0] slot_tag  [MAX_PAGES];
    logic                  slot_live [MAX_PAGES];
    logic [DATA_W-1:0]     word_store [MAX_PAGES*PAGE_WORDS];
    int                    pages_used;
    int                    limit_cfg;
    logic [WORD_IDX_W-1:0] tag_pool [TAGS];

    request_t requests_waiting[$];
    reply_t   replies_due[$];
    request_t offered;
    int       requests_queued = 0;
    int       requests_taken  = 0;
    int       fail_count      = 0;
    bit       steady          = 1'b0;
    bit       hold_done       = 1'b0;
    int       hold_left       = 0;
    int       send_gap        = 0;
    int       send_calm       = 0;
    int       recv_gap        = 0;
    int       recv_calm       = 0;
    int       quiet_cycles    = 0;

    sparse_paged_word_memory i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .address    (address),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .status     (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("error at %0t: %s", $time, what);
    endtask

    // applies one request to the shadow memory and returns its reply
    function automatic reply_t mem_access(request_t r);
        reply_t                rep;
        logic [WORD_IDX_W-1:0] word_idx;
        logic [WORD_IDX_W-1:0] tag;
        int                    offset;
        int                    slot;
        int                    cap;
        int                    i;
        rep.rdata = '0;
        rep.code  = STATUS_DONE;
        if (r.addr == '0 || (r.addr[1:0] & ALIGN_MASK) != 2'd0)
        begin
            rep.code = STATUS_BAD_ADDR;
        end
        else
        begin
            word_idx = r.addr[ADDR_W-1:2];
            tag      = word_idx / WORD_IDX_W'(PAGE_WORDS);
            offset   = int'(word_idx % WORD_IDX_W'(PAGE_WORDS));
            slot     = -1;
            for (i = 0; i < MAX_PAGES; i++)
                if (slot < 0 && slot_live[i] && slot_tag[i] == tag)
                    slot = i;
            if (r.act == ACT_READ)
            begin
                if (slot >= 0)
                    rep.rdata = word_store[slot*PAGE_WORDS + offset];
            end
            else
            begin
                if (slot < 0)
                begin
                    cap = (limit_cfg < MAX_PAGES) ? limit_cfg : MAX_PAGES;
                    if (pages_used >= cap)
                    begin
                        rep.code = STATUS_LIMIT;
                    end
                    else
                    begin
                        slot            = pages_used;
                        slot_live[slot] = 1'b1;
                        slot_tag[slot]  = tag;
                        for (i = 0; i < PAGE_WORDS; i++)
                            word_store[slot*PAGE_WORDS + i] = '0;
                        pages_used++;
                    end
                end
                if (slot >= 0)
                    word_store[slot*PAGE_WORDS + offset] = r.data;
            end
        end
        return rep;
    endfunction

    function automatic int idle_burst(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0)
        begin
            calm = $urandom_range(30, 150);
            return 0;
        end
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(1, 12);
        return 0;
    endfunction

    function automatic request_t random_request();
        request_t              r;
        logic [WORD_IDX_W-1:0] tag;
        int                    offset;
        int                    pick;
        r.act  = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
        r.data = $urandom();
        pick   = $urandom_range(0, 99);
        if (pick < 85)
        begin
            // mostly a few pages and a few words so reads land on written data
            tag    = tag_pool[$urandom_range(0, TAGS-1)];
            offset = $urandom_range(0, 7);
            if ($urandom_range(0, 4) == 0)
                offset = $urandom_range(0, PAGE_WORDS-1);
            else if ($urandom_range(0, 5) == 0)
                offset = PAGE_WORDS - 1 - $urandom_range(0, 3);
            r.addr = {tag * WORD_IDX_W'(PAGE_WORDS) + WORD_IDX_W'(offset), 2'b00};
        end
        else if (pick < 90)
        begin
            r.addr = '0;
        end
        else if (pick < 95)
        begin
            r.addr = $urandom();
            if (r.addr[1:0] == 2'd0)
                r.addr[1:0] = 2'($urandom_range(1, 3));
        end
        else
        begin
            r.addr = $urandom();
        end
        return r;
    endfunction

    task automatic queue_request(input logic act, input logic [ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] data);
        request_t r;
        r.act  = act;
        r.addr = addr;
        r.data = data;
        requests_waiting.push_back(r);
        requests_queued++;
    endtask

    task automatic drain();
        @(posedge clk);
        while (requests_taken != requests_queued || replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_page_limit(input int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_PAGE_LIMIT;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_cfg = value & ((1 << LIMIT_W) - 1);
    endtask

    // sender: offers words from the queue, holds them while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                replies_due.push_back(mem_access(offered));
                requests_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (requests_waiting.size() != 0)
                begin
                    offered = requests_waiting.pop_front();
                    action     <= offered.act;
                    address    <= offered.addr;
                    write_data <= offered.data;
                    in_valid   <= 1'b1;
                    if (!steady)
                        send_gap = idle_burst(send_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each reply and drives the stall pattern
    always @(posedge clk)
    begin
        reply_t want;
        logic   stall_next;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    report_mismatch($sformatf("reply %h status %0d with nothing outstanding",
                                              read_data, status));
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (read_data !== want.rdata)
                        report_mismatch($sformatf("read_data %h, want %h",
                                                  read_data, want.rdata));
                    if (status !== want.code)
                        report_mismatch($sformatf("status %0d, want %0d", status, want.code));
                end
            end
            // one long hold so the block backs up and stalls its input
            if (!hold_done && requests_taken >= 700)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                stall_next = 1'b1;
            end
            else
            begin
                stall_next = 1'b0;
                if (!steady)
                    recv_gap = idle_burst(recv_calm);
            end
            out_stall <= stall_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int phase_limits [8];
        int p;
        int n;
        phase_limits = '{4, 6, 0, 9, 17, 12, 31, 16};
        for (n = 0; n < MAX_PAGES; n++)
        begin
            slot_tag[n]  = '0;
            slot_live[n] = 1'b0;
        end
        for (n = 0; n < MAX_PAGES*PAGE_WORDS; n++)
            word_store[n] = '0;
        slot_live[0] = 1'b1;
        pages_used   = 1;
        limit_cfg    = int'(PAGE_LIMIT_RST);
        tag_pool[0] = '0;
        tag_pool[1] = WORD_IDX_W'(1);
        tag_pool[2] = WORD_IDX_W'(TAG_SPAN - 1);
        tag_pool[3] = WORD_IDX_W'(2);
        tag_pool[4] = WORD_IDX_W'(3);
        for (n = 5; n < TAGS; n++)
            tag_pool[n] = WORD_IDX_W'($urandom() % TAG_SPAN);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // limit at its reset value: hits, misses, new page, bad addresses
        queue_request(ACT_READ,  32'h0000_0004, 32'h1234_5678);
        queue_request(ACT_WRITE, 32'h0000_0004, 32'hFFFF_FFFF);
        queue_request(ACT_READ,  32'h0000_0004, 32'h0000_0000);
        queue_request(ACT_WRITE, 32'hFFFF_FFFC, 32'hA5A5_A5A5);
        queue_request(ACT_READ,  32'hFFFF_FFFC, 32'h0000_0000);
        queue_request(ACT_READ,  32'h1234_5000, 32'h0000_0000);
        queue_request(ACT_READ,  32'h0000_0000, 32'h0000_0000);
        queue_request(ACT_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(ACT_READ,  32'h0000_0001, 32'h0000_0000);
        queue_request(ACT_WRITE, 32'h0000_0002, 32'hDEAD_BEEF);
        queue_request(ACT_READ,  32'h0000_0003, 32'h0000_0000);
        queue_request(ACT_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(ACT_WRITE, 32'h0000_0FFC, 32'h0000_0000);
        queue_request(ACT_READ,  32'h0000_0FFC, 32'h0000_0000);
        drain();

        // at or over the limit: new page refused, existing page still writable; limit 31 then admits a new page
        set_page_limit(2);
        queue_request(ACT_WRITE, 32'h0000_1000, 32'h5A5A_5A5A);
        queue_request(ACT_READ,  32'h0000_1000, 32'h0000_0000);
        queue_request(ACT_WRITE, 32'hFFFF_F000, 32'h0000_0001);
        drain();
        set_page_limit(0);
        queue_request(ACT_WRITE, 32'h0000_2000, 32'h0F0F_0F0F);
        drain();
        set_page_limit(1);
        queue_request(ACT_WRITE, 32'h0000_3000, 32'hF0F0_F0F0);
        drain();
        set_page_limit(31);
        queue_request(ACT_WRITE, 32'h0000_1000, 32'h8000_0001);
        queue_request(ACT_READ,  32'h0000_1000, 32'h0000_0000);
        drain();

        for (p = 0; p < 8; p++)
        begin
            set_page_limit(phase_limits[p]);
            if (p == 7)
                steady = 1'b1;
            for (n = 0; n < BATCH_WORDS; n++)
            begin
                requests_waiting.push_back(random_request());
                requests_queued++;
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && replies_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sparse_paged_word_memory.f
rtl/core/spm_pkg.sv
rtl/core/spm_ram.sv
rtl/core/spm_ctrl.sv
rtl/core/spm_dp.sv
rtl/core/sparse_paged_word_memory.sv
rtl/core/spm_checker.sv
bench/testbench.sv
